// ----- hw/rtl/line_sensor_array_position_core_defines.svh -----
// Assertion macros for the line sensor array position block.
`ifndef LINE_SENSOR_ARRAY_POSITION_CORE_DEFINES_SVH
`define LINE_SENSOR_ARRAY_POSITION_CORE_DEFINES_SVH

// Implication checked at every rising edge outside reset.
`define LSAP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define LSAP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/lsap_pkg.sv -----
// ---------------------------------------------------------------------------
// lsap_pkg
// Types, constants and codes shared by the line sensor position block.
// ---------------------------------------------------------------------------
package lsap_pkg;

    localparam int MAX_SENSORS         = 6;
    localparam int SENSOR_COUNT_DEF    = 6;
    localparam int SAMPLE_W            = 10;
    localparam int WEIGHT_W            = 13;
    localparam int HYST_W              = 9;
    localparam int LIMIT_W             = 12;
    localparam int POS_W               = 13;
    localparam int CFG_IDX_W           = 3;
    localparam int CFG_DATA_W          = 13;
    localparam int MASK_W              = 6;
    // excess up to 1023, weight 13 bits signed, six terms
    localparam int EXC_W               = 13;
    localparam int WSUM_W              = 29;
    localparam int DSUM_W              = 16;
    localparam int STEP_W              = 5;

    typedef enum logic [1:0] {
        CMD_MEASURE = 2'd0,
        CMD_CALIB   = 2'd1,
        CMD_APPLY   = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_VALID    = 2'd0,
        ST_WHITE    = 2'd1,
        ST_BLACK    = 2'd2,
        ST_NO_MEAS  = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HYST   = 3'd0,
        REG_LIMIT  = 3'd1,
        REG_W0     = 3'd2,
        REG_W1     = 3'd3,
        REG_W2     = 3'd4,
        REG_W3     = 3'd5,
        REG_W4     = 3'd6,
        REG_W5     = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACCUM,
        S_DIVIDE,
        S_FINISH,
        S_OUTPUT
    } state_t;

    typedef struct packed {
        logic load;        // capture frame and run compare / calib / apply
        logic accum;       // accumulate one sensor term
        logic div_start;
        logic div_step;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic       measure_mixed;  // measure with partial mask, needs division
        logic       accum_last;
        logic       div_last;
    } ctrl_stat_t;

endpackage

// ----- hw/rtl/lsap_if.sv -----
// ---------------------------------------------------------------------------
// lsap_if
// Valid/ready channel carrying a packed payload.
// ---------------------------------------------------------------------------
interface lsap_if #(
    parameter int W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/line_sensor_array_position_core.sv -----
// ---------------------------------------------------------------------------
// line_sensor_array_position_core
// Line sensor row position: hysteresis compare, weighted centroid.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch  : one beat = cmd plus six samples; cmd 0 measure, 1 calibrate,
//            2 apply midpoint thresholds.
//   out_ch : one beat per input beat: on_mask, position, status, centered,
//            line_found.
//   cfg_ch : register index and data; write only while idle.
// Sequence: calibrate, apply, unused commands and measures with all or no
//   sensor on pass from the load through the accumulate state to the output
//   beat; a measure with a partial mask takes SENSOR_COUNT accumulate steps,
//   one divider setup and 28 divider steps of the bit-serial restoring
//   divider.
// One item is in flight at a time; input ready is high only when idle, so the
//   next input beat is taken in the cycle after the result beat at the earliest.
// Reset restores default registers, thresholds at half scale, min/max at
//   their extremes and clears the hysteresis memory.
// A stalled receiver holds the result beat stable and blocks the input.
// ---------------------------------------------------------------------------
module line_sensor_array_position_core #(
    parameter int SENSOR_COUNT = lsap_pkg::SENSOR_COUNT_DEF
) (
    input logic clk,
    input logic rst_n,
    lsap_if.sink   in_ch,
    lsap_if.sink   cfg_ch,
    lsap_if.source out_ch
);
    import lsap_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;
    logic [MAX_SENSORS-1:0][SAMPLE_W-1:0] smp;
    logic [MASK_W-1:0]        on_mask;
    logic signed [POS_W-1:0]  position;
    logic [1:0]               status;
    logic                     centered;
    logic                     line_found;

    // in_ch.data: {sample_5 .. sample_0, cmd}; out_ch.data:
    // {line_found, centered, status, position, on_mask}
    // cfg_ch.data: {index[2:0], data[12:0]}
    assign smp = in_ch.data[2 +: MAX_SENSORS*SAMPLE_W];
    assign cfg_ch.ready = 1'b1;
    assign out_ch.data = {line_found, centered, status, position, on_mask};

    lsap_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    lsap_datapath #(
        .SENSOR_COUNT(SENSOR_COUNT)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_ch.valid),
        .cfg_idx    (cfg_ch.data[CFG_DATA_W +: CFG_IDX_W]),
        .cfg_data   (cfg_ch.data[CFG_DATA_W-1:0]),
        .in_cmd     (in_ch.data[1:0]),
        .in_sample  (smp),
        .cmd        (cmd),
        .stat       (stat),
        .on_mask    (on_mask),
        .position   (position),
        .status     (status),
        .centered   (centered),
        .line_found (line_found)
    );

endmodule

// ----- hw/rtl/lsap_ctrl.sv -----
// ---------------------------------------------------------------------------
// lsap_ctrl
// Sequencer: frame load, per-sensor accumulation, division, result hold.
// ---------------------------------------------------------------------------
`include "line_sensor_array_position_core_defines.svh"

module lsap_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output lsap_pkg::ctrl_cmd_t   cmd,
    input  lsap_pkg::ctrl_stat_t  stat
);
    import lsap_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_ACCUM;
                end
            end
            S_ACCUM:
            begin
                if (!stat.measure_mixed)
                begin
                    state_next = S_OUTPUT;
                end
                else
                begin
                    cmd.accum = 1'b1;
                    if (stat.accum_last)
                    begin
                        state_next = S_DIVIDE;
                    end
                end
            end
            S_DIVIDE:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_OUTPUT;
                end
            end
            S_OUTPUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `LSAP_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ready, !out_valid)
    `LSAP_ASSERT_NEXT(a_load_leaves, clk, rst_n, cmd.load, state_reg == S_ACCUM)
    `LSAP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

endmodule

// ----- hw/rtl/lsap_datapath.sv -----
// ---------------------------------------------------------------------------
// lsap_datapath
// Sensor state, threshold compare, serial accumulation, restoring divider.
// ---------------------------------------------------------------------------
`include "line_sensor_array_position_core_defines.svh"

module lsap_datapath #(
    parameter int SENSOR_COUNT = lsap_pkg::SENSOR_COUNT_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [lsap_pkg::CFG_IDX_W-1:0]          cfg_idx,
    input  logic [lsap_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic [1:0]                              in_cmd,
    input  logic [lsap_pkg::MAX_SENSORS-1:0][lsap_pkg::SAMPLE_W-1:0] in_sample,
    input  lsap_pkg::ctrl_cmd_t                     cmd,
    output lsap_pkg::ctrl_stat_t                    stat,
    output logic [lsap_pkg::MASK_W-1:0]             on_mask,
    output logic signed [lsap_pkg::POS_W-1:0]       position,
    output logic [1:0]                              status,
    output logic                                    centered,
    output logic                                    line_found
);
    import lsap_pkg::*;

    localparam int SAMPLE_BITS = SAMPLE_W;
    localparam int SENS_IDX_W = $clog2(SENSOR_COUNT);
    localparam logic [SAMPLE_BITS-1:0] S_MAX  = {SAMPLE_BITS{1'b1}};
    localparam logic [SAMPLE_BITS-1:0] S_HALF = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [MASK_W-1:0] ALL_MASK = MASK_W'((1 << SENSOR_COUNT) - 1);
    localparam int DIV_STEPS = WSUM_W - 1;
    localparam int MAG_W = WSUM_W - 1;

    logic [HYST_W-1:0]                    hyst_reg;
    logic [LIMIT_W-1:0]                   limit_reg;
    logic signed [WEIGHT_W-1:0]           weight_reg [MAX_SENSORS];
    logic [SAMPLE_BITS-1:0]               low_reg  [SENSOR_COUNT];
    logic [SAMPLE_BITS-1:0]               high_reg [SENSOR_COUNT];
    logic [SAMPLE_BITS-1:0]               thr_reg  [SENSOR_COUNT];
    logic [MASK_W-1:0]                    mem_reg;
    logic [SAMPLE_BITS-1:0]               smp_reg  [SENSOR_COUNT];
    logic [MASK_W-1:0]                    mask_reg;
    logic [1:0]                           status_reg;
    logic [SENS_IDX_W-1:0]                idx_reg;
    logic signed [WSUM_W-1:0]             wsum_reg;
    logic [DSUM_W-1:0]                    dsum_reg;
    logic [MAG_W-1:0]                     quo_reg;
    logic [DSUM_W:0]                      rem_reg;
    logic                                 neg_reg;
    logic [STEP_W-1:0]                    step_reg;
    logic signed [POS_W-1:0]              pos_reg;
    logic                                 cent_reg;
    logic [MASK_W-1:0]                    mask_next;
    logic signed [EXC_W-1:0]              exc;
    logic signed [WEIGHT_W+EXC_W-1:0]     prod;
    logic [DSUM_W:0]                      rem_sh;
    logic [MAG_W-1:0]                     quo_sh;
    logic signed [POS_W-1:0]              pos_final;
    logic [POS_W-1:0]                     pos_abs;

    always_comb
    begin
        mask_next = '0;
        for (int i = 0; i < SENSOR_COUNT; i++)
        begin
            logic signed [SAMPLE_BITS+1:0] edge_v;
            if (mem_reg[i])
            begin
                edge_v = $signed({2'b00, thr_reg[i]}) - $signed((SAMPLE_BITS+2)'(hyst_reg));
            end
            else
            begin
                edge_v = $signed({2'b00, thr_reg[i]}) + $signed((SAMPLE_BITS+2)'(hyst_reg));
            end
            mask_next[i] = $signed({2'b00, in_sample[i][SAMPLE_BITS-1:0]}) > edge_v;
        end
    end

    always_comb
    begin
        exc = EXC_W'($signed({1'b0, smp_reg[idx_reg]}))
            - EXC_W'($signed({1'b0, thr_reg[idx_reg]}));
        if (exc < EXC_W'(1))
        begin
            exc = EXC_W'(1);
        end
        prod   = weight_reg[idx_reg] * exc;
        rem_sh = {rem_reg[DSUM_W-1:0], quo_reg[MAG_W-1]};
        quo_sh = {quo_reg[MAG_W-2:0], 1'b0};
        if (rem_sh >= {1'b0, dsum_reg})
        begin
            rem_sh    = rem_sh - {1'b0, dsum_reg};
            quo_sh[0] = 1'b1;
        end
        pos_final = neg_reg ? -POS_W'(quo_sh) : POS_W'(quo_sh);
        pos_abs   = neg_reg ? POS_W'(quo_sh) : POS_W'(quo_sh);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hyst_reg  <= HYST_W'(20);
            limit_reg <= LIMIT_W'(100);
            weight_reg[0] <= -WEIGHT_W'(2500);
            weight_reg[1] <= -WEIGHT_W'(1500);
            weight_reg[2] <= -WEIGHT_W'(500);
            weight_reg[3] <= WEIGHT_W'(500);
            weight_reg[4] <= WEIGHT_W'(1500);
            weight_reg[5] <= WEIGHT_W'(2500);
            for (int i = 0; i < SENSOR_COUNT; i++)
            begin
                low_reg[i]  <= S_MAX;
                high_reg[i] <= '0;
                thr_reg[i]  <= S_HALF;
            end
            mem_reg    <= '0;
            mask_reg   <= '0;
            status_reg <= ST_NO_MEAS;
            idx_reg    <= '0;
            step_reg   <= '0;
            pos_reg    <= '0;
            cent_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (reg_idx_t'(cfg_idx))
                    REG_HYST:  hyst_reg  <= cfg_data[HYST_W-1:0];
                    REG_LIMIT: limit_reg <= cfg_data[LIMIT_W-1:0];
                    default:   weight_reg[cfg_idx - CFG_IDX_W'(2)] <= $signed(cfg_data);
                endcase
            end
            if (cmd.load)
            begin
                for (int i = 0; i < SENSOR_COUNT; i++)
                begin
                    smp_reg[i] <= in_sample[i][SAMPLE_BITS-1:0];
                end
                idx_reg  <= '0;
                wsum_reg <= '0;
                dsum_reg <= '0;
                pos_reg  <= '0;
                cent_reg <= 1'b0;
                mask_reg <= '0;
                status_reg <= ST_NO_MEAS;
                case (in_cmd)
                    CMD_MEASURE:
                    begin
                        mem_reg  <= mask_next;
                        mask_reg <= mask_next;
                        if (mask_next == ALL_MASK)
                        begin
                            status_reg <= ST_BLACK;
                        end
                        else if (mask_next == '0)
                        begin
                            status_reg <= ST_WHITE;
                        end
                        else
                        begin
                            status_reg <= ST_VALID;
                        end
                    end
                    CMD_CALIB:
                    begin
                        for (int i = 0; i < SENSOR_COUNT; i++)
                        begin
                            if (in_sample[i][SAMPLE_BITS-1:0] < low_reg[i])
                            begin
                                low_reg[i] <= in_sample[i][SAMPLE_BITS-1:0];
                            end
                            if (in_sample[i][SAMPLE_BITS-1:0] > high_reg[i])
                            begin
                                high_reg[i] <= in_sample[i][SAMPLE_BITS-1:0];
                            end
                        end
                    end
                    CMD_APPLY:
                    begin
                        for (int i = 0; i < SENSOR_COUNT; i++)
                        begin
                            thr_reg[i] <= SAMPLE_BITS'(({1'b0, low_reg[i]}
                                + {1'b0, high_reg[i]}) >> 1);
                        end
                        mem_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.accum)
            begin
                if (mask_reg[idx_reg])
                begin
                    wsum_reg <= wsum_reg + WSUM_W'(prod);
                    dsum_reg <= dsum_reg + DSUM_W'(exc);
                end
                if (!stat.accum_last)
                begin
                    idx_reg <= idx_reg + SENS_IDX_W'(1);
                end
            end
            if (cmd.div_start)
            begin
                neg_reg  <= wsum_reg[WSUM_W-1];
                quo_reg  <= wsum_reg[WSUM_W-1] ? MAG_W'(-wsum_reg) : MAG_W'(wsum_reg);
                rem_reg  <= '0;
                step_reg <= '0;
            end
            if (cmd.div_step)
            begin
                quo_reg  <= quo_sh;
                rem_reg  <= rem_sh;
                step_reg <= step_reg + STEP_W'(1);
            end
            if (cmd.finish)
            begin
                pos_reg  <= pos_final;
                cent_reg <= {1'b0, pos_abs} <= {2'b00, limit_reg};
            end
        end
    end

    assign stat.measure_mixed = (status_reg == ST_VALID);
    assign stat.accum_last    = (idx_reg == SENS_IDX_W'(SENSOR_COUNT - 1));
    assign stat.div_last      = (step_reg == STEP_W'(DIV_STEPS - 1));

    assign on_mask    = mask_reg;
    assign position   = pos_reg;
    assign status     = status_reg;
    assign centered   = cent_reg;
    assign line_found = (mask_reg != '0);

    `LSAP_ASSERT_IMP(a_mask_range, clk, rst_n, 1'b1, (mask_reg & ~ALL_MASK) == '0)
    `LSAP_ASSERT_IMP(a_pos_zero, clk, rst_n, status_reg != ST_VALID, pos_reg == '0 && !cent_reg)
    `LSAP_ASSERT_IMP(a_dsum_pos, clk, rst_n, cmd.div_start, dsum_reg != '0)

endmodule

// ----- test/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// Testbench for line_sensor_array_position_core.
// Drives command frames and register writes, and predicts every result beat
// with its own model of hysteresis, calibration and the centroid. Each output
// beat is checked field by field against the oldest prediction. Both sides
// idle at random.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lsap_pkg::*;

    localparam int IN_W  = 2 + 6 * SAMPLE_W;
    localparam int OUT_W = MASK_W + POS_W + 2 + 1 + 1;
    localparam int CFG_W = CFG_IDX_W + CFG_DATA_W;

    typedef struct packed {
        logic              line_found;
        logic              centered;
        status_t           status;
        logic [POS_W-1:0]  position;
        logic [MASK_W-1:0] on_mask;
    } line_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lsap_if #(.W(IN_W))  in_ch ();
    lsap_if #(.W(CFG_W)) cfg_ch ();
    lsap_if #(.W(OUT_W)) out_ch ();

    line_sensor_array_position_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .cfg_ch (cfg_ch),
        .out_ch (out_ch)
    );

    always #5 clk = ~clk;

    // shadow state of the block
    logic [HYST_W-1:0]   hyst;
    logic [LIMIT_W-1:0]  limit;
    logic signed [WEIGHT_W-1:0] weight [6];
    logic [SAMPLE_W-1:0] lo_seen [6];
    logic [SAMPLE_W-1:0] hi_seen [6];
    logic [SAMPLE_W-1:0] thresh [6];
    logic [5:0]          on_mem;

    line_result_t pending_results [$];
    int errors = 0;
    int frames_sent = 0;
    int beats_checked = 0;
    int idle_pct = 0;
    int stall_pct = 0;

    task automatic report(input string what, input int got, input int want);
        errors++;
        $display("tb: mismatch %s got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    function automatic line_result_t frame_outcome(input cmd_t cmd,
                                                   input logic [SAMPLE_W-1:0] s [6]);
        line_result_t r;
        logic [5:0] m;
        longint edge_lvl, d, wsum, dsum, pos, apos;
        r = '0;
        r.status = ST_NO_MEAS;
        m = '0;
        wsum = 0;
        dsum = 0;
        case (cmd)
            CMD_CALIB:
                for (int i = 0; i < 6; i++)
                begin
                    if (s[i] < lo_seen[i]) lo_seen[i] = s[i];
                    if (s[i] > hi_seen[i]) hi_seen[i] = s[i];
                end
            CMD_APPLY:
            begin
                for (int i = 0; i < 6; i++)
                    thresh[i] = SAMPLE_W'((11'(lo_seen[i]) + 11'(hi_seen[i])) >> 1);
                on_mem = '0;
            end
            CMD_MEASURE:
            begin
                for (int i = 0; i < 6; i++)
                begin
                    edge_lvl = on_mem[i] ? longint'(thresh[i]) - longint'(hyst)
                                         : longint'(thresh[i]) + longint'(hyst);
                    if (longint'(s[i]) > edge_lvl) m[i] = 1'b1;
                end
                on_mem = m;
                r.on_mask = m;
                r.line_found = (m != 0);
                if (m == 6'h3f) r.status = ST_BLACK;
                else if (m == 0) r.status = ST_WHITE;
                else
                begin
                    for (int i = 0; i < 6; i++)
                        if (m[i])
                        begin
                            d = longint'(s[i]) - longint'(thresh[i]);
                            if (d < 1) d = 1;
                            wsum += longint'(weight[i]) * d;
                            dsum += d;
                        end
                    pos = wsum / dsum;
                    apos = pos < 0 ? -pos : pos;
                    r.position = pos[POS_W-1:0];
                    r.status = ST_VALID;
                    r.centered = (apos <= longint'(limit));
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_frame(input cmd_t cmd, input logic [SAMPLE_W-1:0] s [6]);
        int gap;
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= {s[5], s[4], s[3], s[2], s[1], s[0], cmd};
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        pending_results.push_back(frame_outcome(cmd, s));
        frames_sent++;
    endtask

    task automatic drain;
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= {idx, val};
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_HYST:  hyst = val[HYST_W-1:0];
            REG_LIMIT: limit = val[LIMIT_W-1:0];
            default:   weight[int'(idx) - int'(REG_W0)] = val;
        endcase
        @(posedge clk);
    endtask

    task automatic send_flat(input cmd_t cmd, input int v);
        logic [SAMPLE_W-1:0] s [6];
        foreach (s[i]) s[i] = SAMPLE_W'(v);
        send_frame(cmd, s);
    endtask

    // sample near the current threshold so hysteresis matters
    task automatic send_near(input cmd_t cmd);
        logic [SAMPLE_W-1:0] s [6];
        int v;
        foreach (s[i])
        begin
            case ($urandom_range(3))
                0: s[i] = SAMPLE_W'($urandom_range(1023));
                default:
                begin
                    v = int'(thresh[i]) + int'($urandom_range(160)) - 80;
                    s[i] = SAMPLE_W'((v < 0) ? 0 : (v > 1023) ? 1023 : v);
                end
            endcase
        end
        send_frame(cmd, s);
    endtask

    task automatic test_directed;
        logic [SAMPLE_W-1:0] s [6];
        send_flat(CMD_MEASURE, 1023);
        send_flat(CMD_MEASURE, 0);
        send_flat(CMD_MEASURE, 531);
        send_flat(CMD_MEASURE, 532);
        s = '{1023, 0, 0, 0, 0, 0};
        send_frame(CMD_MEASURE, s);
        s = '{0, 0, 0, 0, 0, 1023};
        send_frame(CMD_MEASURE, s);
        s = '{0, 0, 600, 700, 0, 0};
        send_frame(CMD_MEASURE, s);
        s = '{0, 0, 495, 700, 0, 0};
        send_frame(CMD_MEASURE, s);
        send_flat(CMD_NONE, 1023);
        send_flat(CMD_APPLY, 0);
        send_flat(CMD_MEASURE, 512);
        send_flat(CMD_CALIB, 0);
        send_flat(CMD_CALIB, 1023);
        s = '{100, 200, 300, 400, 500, 600};
        send_frame(CMD_CALIB, s);
        send_flat(CMD_APPLY, 1023);
        s = '{1023, 1023, 1023, 0, 0, 1023};
        send_frame(CMD_MEASURE, s);
        s = '{520, 0, 0, 0, 0, 522};
        send_frame(CMD_MEASURE, s);
        send_flat(CMD_NONE, 0);
        drain();
    endtask

    task automatic test_extreme_regs;
        logic [SAMPLE_W-1:0] s [6];
        write_reg(REG_HYST, 511);
        write_reg(REG_LIMIT, 4095);
        for (int i = 0; i < 6; i++)
            write_reg(reg_idx_t'(int'(REG_W0) + i), (i % 2) ? 13'h0fff : 13'h1000);
        s = '{1023, 1023, 0, 0, 0, 1023};
        send_frame(CMD_MEASURE, s);
        send_flat(CMD_MEASURE, 1023);
        drain();
        write_reg(REG_HYST, 0);
        write_reg(REG_LIMIT, 0);
        s = '{1023, 600, 0, 0, 0, 0};
        send_frame(CMD_MEASURE, s);
        s = '{0, 1023, 0, 0, 0, 0};
        send_frame(CMD_MEASURE, s);
        drain();
    endtask

    task automatic random_regs;
        write_reg(REG_HYST, CFG_DATA_W'($urandom_range(3) == 0 ? 0 : $urandom_range(60)));
        write_reg(REG_LIMIT,
                  CFG_DATA_W'($urandom_range(3) == 0 ? 4095 : $urandom_range(600)));
        for (int i = 0; i < 6; i++)
            write_reg(reg_idx_t'(int'(REG_W0) + i), CFG_DATA_W'($urandom));
    endtask

    task automatic test_random_phase(input int idle_p, input int stall_p, input int n);
        idle_pct = idle_p;
        stall_pct = stall_p;
        random_regs();
        for (int k = 0; k < n; k++)
        begin
            case ($urandom_range(19))
                0, 1: send_near(CMD_CALIB);
                2:    send_flat(CMD_APPLY, $urandom_range(1023));
                3:    send_flat(CMD_NONE, $urandom_range(1023));
                4:
                begin
                    // fresh calibration then threshold update
                    repeat ($urandom_range(1, 4)) send_near(CMD_CALIB);
                    send_near(CMD_APPLY);
                end
                default: send_near(CMD_MEASURE);
            endcase
            if (k == n / 2) drain();
        end
        drain();
    endtask

    // result checker
    always @(posedge clk)
    begin
        line_result_t got, want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            if (pending_results.size() == 0)
                report("unexpected beat", 0, 1);
            else
            begin
                want = pending_results.pop_front();
                beats_checked++;
                if (got.on_mask !== want.on_mask)
                    report("on_mask", got.on_mask, want.on_mask);
                if (got.position !== want.position)
                    report("position", $signed(got.position), $signed(want.position));
                if (got.status !== want.status)
                    report("status", got.status, want.status);
                if (got.centered !== want.centered)
                    report("centered", got.centered, want.centered);
                if (got.line_found !== want.line_found)
                    report("line_found", got.line_found, want.line_found);
            end
        end
    end

    always @(posedge clk)
        out_ch.ready <= ($urandom_range(99) >= stall_pct);

    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        out_ch.ready = 1'b0;
        hyst = 20;
        limit = 100;
        weight = '{-2500, -1500, -500, 500, 1500, 2500};
        foreach (thresh[i])
        begin
            lo_seen[i] = 1023;
            hi_seen[i] = 0;
            thresh[i] = 512;
        end
        on_mem = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_extreme_regs();
        test_random_phase(0, 0, 210);
        test_random_phase(66, 0, 210);
        test_random_phase(0, 66, 210);
        test_random_phase(35, 35, 210);

        $display("tb: %0d frames sent, %0d result beats checked", frames_sent, beats_checked);
        $display("tb: measure/calibrate/apply/unused commands, register extremes, four idle mixes");
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/lsap_pkg.sv
hw/rtl/lsap_if.sv
hw/rtl/lsap_ctrl.sv
hw/rtl/lsap_datapath.sv
hw/rtl/line_sensor_array_position_core.sv
test/tb.sv
